// ----- rtl/core/max_pool_2d_stream_macros.svh -----
// ----------------------------------------------------------------------------
// max_pool_2d_stream assertion macros
// concurrent checks on i_clk, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_MACROS_SVH
`define MAX_POOL_2D_STREAM_MACROS_SVH
`ifndef SYNTH
// checked outside reset only
`define MP2DS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("max_pool_2d_stream: check failed");
// checked at every edge, reset included
`define MP2DS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("max_pool_2d_stream: check failed");
`else
`define MP2DS_ASSERT(label, prop)
`define MP2DS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/core/mp2ds_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2ds_pkg
// shared types and constants of the streaming 2d max pooling block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mp2ds_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int KERNEL_BITS   = 4;
    localparam int STRIDE_BITS   = 4;
    localparam int PLANE_BITS    = 11;

    localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = 4'd2;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 4'd2;
    localparam logic [PLANE_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [PLANE_BITS-1:0]  HEIGHT_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KERNEL_SIZE  = 2'd0,
        CFG_STRIDE       = 2'd1,
        CFG_PLANE_WIDTH  = 2'd2,
        CFG_PLANE_HEIGHT = 2'd3
    } t_cfg_idx;

    // line buffer port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctrl;

endpackage

// ----- rtl/core/mp2ds_in_if.sv -----
// ----------------------------------------------------------------------------
// mp2ds_in_if
// sample stream channel: valid, ready and one signed sample per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mp2ds_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/mp2ds_out_if.sv -----
// ----------------------------------------------------------------------------
// mp2ds_out_if
// pooled result channel: window maximum and end of plane flag per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mp2ds_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic                          end_of_plane;

    modport source (output valid, output pooled_value, output end_of_plane, input ready);
    modport sink   (input valid, input pooled_value, input end_of_plane, output ready);
endinterface

// ----- rtl/core/mp2ds_line_cell.sv -----
// ----------------------------------------------------------------------------
// mp2ds_line_cell
// one row delay of the vertical chain: a line buffer that hands the row it
// held to the next cell and folds that row into the running column maximum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2ds_line_cell import mp2ds_pkg::*; #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 16,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  t_mem_ctrl                   i_ctrl,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic signed [DATA_BITS-1:0] i_wr_data,
    input  logic                        i_use,
    input  logic signed [DATA_BITS-1:0] i_max,
    output logic signed [DATA_BITS-1:0] o_rd_data,
    output logic signed [DATA_BITS-1:0] o_max
);

    logic signed [DATA_BITS-1:0] r_line [DEPTH];
    logic signed [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_line[i_wr_addr] <= i_wr_data;
        end
    end

    // a one-sample-wide plane reads the column that is written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            if (i_ctrl.wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_line[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_max     = (i_use && (r_rd_data > i_max)) ? r_rd_data : i_max;

endmodule

// ----- rtl/core/mp2ds_win_cell.sv -----
// ----------------------------------------------------------------------------
// mp2ds_win_cell
// one column of the horizontal window: holds a column maximum, shifts it on
// to its neighbor and folds it into the running window maximum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2ds_win_cell #(
    parameter int DATA_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic signed [DATA_BITS-1:0] i_data,
    input  logic                        i_use,
    input  logic signed [DATA_BITS-1:0] i_max,
    output logic signed [DATA_BITS-1:0] o_data,
    output logic signed [DATA_BITS-1:0] o_max
);

    logic signed [DATA_BITS-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_data;
        end
    end

    assign o_data = r_val;
    assign o_max  = (i_use && (r_val > i_max)) ? r_val : i_max;

endmodule

// ----- rtl/core/max_pool_2d_stream.sv -----
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming max pooling over square windows of a raster-order feature map.
// Takes one sample per clock while the output side keeps up, through three
// register stages: the sample completing a window is held in r_s1, then r_s2,
// and o_out.valid rises when the output register loads the window maximum. The rate is set by the line
// buffers: each cell of the row chain does one read and one write of its
// buffer per sample. Planes follow back to back.
// Each axis yields (size-kernel)/stride+1 results; the last of a plane
// carries end_of_plane. A configuration write restarts the plane at row 0,
// column 0 and is to be done while no sample is in flight. The row buffers
// need no clearing after reset: a window only uses rows of its own plane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_pool_2d_stream_macros.svh"

module max_pool_2d_stream import mp2ds_pkg::*; #(
    parameter int MAX_KERNEL  = 8,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    mp2ds_in_if.sink                 i_in,
    mp2ds_out_if.source              o_out
);

    localparam int NSLOT = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PW    = (CW > RW) ? CW : RW;
    localparam int LW    = ((PW > PLANE_BITS) ? PW : PLANE_BITS) + 1;

    // configuration
    logic [KERNEL_BITS-1:0] r_kernel;
    logic [STRIDE_BITS-1:0] r_stride;
    logic [PLANE_BITS-1:0]  r_pwidth;
    logic [PLANE_BITS-1:0]  r_pheight;

    logic [STRIDE_BITS-1:0] w_s4;
    logic [LW-1:0]          w_k;
    logic [LW-1:0]          w_s;
    logic [LW-1:0]          w_w;
    logic [LW-1:0]          w_h;

    // plane position and stride phases
    logic [CW-1:0]          r_col;
    logic [RW-1:0]          r_row;
    logic [STRIDE_BITS-1:0] r_cph;
    logic [STRIDE_BITS-1:0] r_rph;
    logic [CW-1:0]          n_col;
    logic [RW-1:0]          n_row;
    logic [STRIDE_BITS-1:0] n_cph;
    logic [STRIDE_BITS-1:0] n_rph;

    logic [LW-1:0] w_col_l;
    logic [LW-1:0] w_row_l;
    logic          w_col_in;
    logic          w_row_in;
    logic          w_last_col;
    logic          w_last_row;
    logic          w_emit;
    logic          w_eop;

    // pipeline
    logic w_accept;
    logic w_in_ready;
    logic w_s1_adv;
    logic w_s2_adv;
    logic w_out_load;

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [CW-1:0]                 r_s1_col;
    logic                          r_s1_emit;
    logic                          r_s1_eop;

    logic                          r_s2_valid;
    logic signed [SAMPLE_BITS-1:0] r_s2_colmax;
    logic                          r_s2_emit;
    logic                          r_s2_eop;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_eop;

    t_mem_ctrl                     w_mem_ctrl;
    logic signed [SAMPLE_BITS-1:0] w_line_rd  [NSLOT];
    logic signed [SAMPLE_BITS-1:0] w_line_max [NSLOT+1];
    logic signed [SAMPLE_BITS-1:0] w_win_data [NSLOT];
    logic signed [SAMPLE_BITS-1:0] w_win_max  [NSLOT+1];

    // ------------------------------------------------------------------
    // effective configuration
    // ------------------------------------------------------------------
    always_comb begin
        w_s4 = (r_stride == '0) ? STRIDE_BITS'(1) : r_stride;
        w_s  = LW'(w_s4);

        if (r_kernel == '0) begin
            w_k = LW'(1);
        end else if (LW'(r_kernel) > LW'(MAX_KERNEL)) begin
            w_k = LW'(MAX_KERNEL);
        end else begin
            w_k = LW'(r_kernel);
        end

        if (r_pwidth == '0) begin
            w_w = LW'(1);
        end else if (LW'(r_pwidth) > LW'(MAX_WIDTH)) begin
            w_w = LW'(MAX_WIDTH);
        end else begin
            w_w = LW'(r_pwidth);
        end

        if (r_pheight == '0) begin
            w_h = LW'(1);
        end else if (LW'(r_pheight) > LW'(MAX_HEIGHT)) begin
            w_h = LW'(MAX_HEIGHT);
        end else begin
            w_h = LW'(r_pheight);
        end
    end

    // ------------------------------------------------------------------
    // position tracking: a phase is zero on rows and columns where a
    // window can end once the first full window fits
    // ------------------------------------------------------------------
    always_comb begin
        w_col_l    = LW'(r_col);
        w_row_l    = LW'(r_row);
        w_col_in   = (w_col_l + LW'(1)) >= w_k;
        w_row_in   = (w_row_l + LW'(1)) >= w_k;
        w_last_col = (w_col_l + LW'(1)) == w_w;
        w_last_row = (w_row_l + LW'(1)) == w_h;
        w_emit     = w_col_in && w_row_in && (r_cph == '0) && (r_rph == '0);
        // no further window fits below or to the right
        w_eop      = w_emit && ((w_row_l + w_s) >= w_h) && ((w_col_l + w_s) >= w_w);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_cph = r_cph;
        n_rph = r_rph;
        if (w_last_col) begin
            n_col = '0;
            n_cph = '0;
            if (w_last_row) begin
                n_row = '0;
                n_rph = '0;
            end else begin
                n_row = r_row + RW'(1);
                if (!w_row_in) begin
                    n_rph = '0;
                end else if (({1'b0, r_rph} + 1'b1) == {1'b0, w_s4}) begin
                    n_rph = '0;
                end else begin
                    n_rph = r_rph + STRIDE_BITS'(1);
                end
            end
        end else begin
            n_col = r_col + CW'(1);
            if (!w_col_in) begin
                n_cph = '0;
            end else if (({1'b0, r_cph} + 1'b1) == {1'b0, w_s4}) begin
                n_cph = '0;
            end else begin
                n_cph = r_cph + STRIDE_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= KERNEL_RESET;
            r_stride  <= STRIDE_RESET;
            r_pwidth  <= WIDTH_RESET;
            r_pheight <= HEIGHT_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_cph     <= '0;
            r_rph     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL_SIZE:  r_kernel  <= i_cfg_data[KERNEL_BITS-1:0];
                CFG_STRIDE:       r_stride  <= i_cfg_data[STRIDE_BITS-1:0];
                CFG_PLANE_WIDTH:  r_pwidth  <= i_cfg_data[PLANE_BITS-1:0];
                CFG_PLANE_HEIGHT: r_pheight <= i_cfg_data[PLANE_BITS-1:0];
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
            r_cph <= '0;
            r_rph <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_cph <= n_cph;
            r_rph <= n_rph;
        end
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    assign w_s2_adv   = r_s2_valid && (!r_s2_emit || !r_out_valid || o_out.ready);
    assign w_s1_adv   = r_s1_valid && (!r_s2_valid || w_s2_adv);
    assign w_in_ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_out_load = w_s2_adv && r_s2_emit;

    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_in.sample;
            r_s1_col    <= r_col;
            r_s1_emit   <= w_emit;
            r_s1_eop    <= w_eop;
        end
        if (w_s1_adv) begin
            r_s2_colmax <= w_line_max[NSLOT];
            r_s2_emit   <= r_s1_emit;
            r_s2_eop    <= r_s1_eop;
        end
        if (w_out_load) begin
            r_out_value <= w_win_max[NSLOT];
            r_out_eop   <= r_s2_eop;
        end
    end

    // ------------------------------------------------------------------
    // row chain: cell g holds the row g+1 above the incoming sample
    // ------------------------------------------------------------------
    assign w_mem_ctrl.rd_en = w_accept;
    assign w_mem_ctrl.wr_en = w_s1_adv;
    assign w_line_max[0]    = r_s1_sample;

    for (genvar g = 0; g < NSLOT; g++) begin : g_line
        logic signed [SAMPLE_BITS-1:0] w_wr_data;
        logic                          w_use;

        if (g == 0) begin : g_head
            assign w_wr_data = r_s1_sample;
        end else begin : g_body
            assign w_wr_data = w_line_rd[g-1];
        end
        assign w_use = LW'(g + 1) < w_k;

        mp2ds_line_cell #(
            .DEPTH     (MAX_WIDTH),
            .DATA_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_mem_ctrl),
            .i_rd_addr (r_col),
            .i_wr_addr (r_s1_col),
            .i_wr_data (w_wr_data),
            .i_use     (w_use),
            .i_max     (w_line_max[g]),
            .o_rd_data (w_line_rd[g]),
            .o_max     (w_line_max[g+1])
        );
    end

    // ------------------------------------------------------------------
    // window chain: cell g holds the column maximum g+1 to the left
    // ------------------------------------------------------------------
    assign w_win_max[0] = r_s2_colmax;

    for (genvar g = 0; g < NSLOT; g++) begin : g_win
        logic signed [SAMPLE_BITS-1:0] w_shift_in;
        logic                          w_use;

        if (g == 0) begin : g_head
            assign w_shift_in = r_s2_colmax;
        end else begin : g_body
            assign w_shift_in = w_win_data[g-1];
        end
        assign w_use = LW'(g + 1) < w_k;

        mp2ds_win_cell #(
            .DATA_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_s2_adv),
            .i_data  (w_shift_in),
            .i_use   (w_use),
            .i_max   (w_win_max[g]),
            .o_data  (w_win_data[g]),
            .o_max   (w_win_max[g+1])
        );
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pooled_value = r_out_value;
    assign o_out.end_of_plane = r_out_eop;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `MP2DS_ASSERT_ALWAYS(a_reset_flushes, !i_rst_n |=> (!r_s1_valid && !r_s2_valid && !r_out_valid))
    `MP2DS_ASSERT(a_col_in_plane, (LW'(r_col) < w_w) && (LW'(r_row) < w_h))
    `MP2DS_ASSERT(a_eop_on_window, (r_s1_valid && r_s1_eop) |-> r_s1_emit)
    `MP2DS_ASSERT(a_cfg_restarts, i_cfg_we |=> (r_col == '0 && r_row == '0 && r_cph == '0))

endmodule
